### rtl/uv_sphere_mesh_element_generator_top_assert.svh
// ----------------------------------------------------------------------------
// uv sphere element generator assertion macros
// Shared property wrappers; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_MESH_ELEMENT_GENERATOR_TOP_ASSERT_SVH
`define UV_SPHERE_MESH_ELEMENT_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define UVS_CHECK(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uvs check failed");

// next-cycle implication
`define UVS_CHECK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uvs next-cycle check failed");

`endif

### rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared constants, codes and types of the uv sphere element generator.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

  // field widths
  localparam int IDX_W      = 17;
  localparam int CNT_W      = 9;
  localparam int RAD_W      = 16;
  localparam int POS_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PHASE_W    = 16;

  // default size limits
  localparam int DEF_MAX_SLICES = 256;
  localparam int DEF_MAX_STACKS = 256;

  // register reset values and lower clamps
  localparam logic [CNT_W-1:0] RST_SLICES = 9'd8;
  localparam logic [CNT_W-1:0] RST_STACKS = 9'd4;
  localparam logic [RAD_W-1:0] RST_RADIUS = 16'd256;
  localparam logic [CNT_W-1:0] MIN_SLICES = 9'd3;
  localparam logic [CNT_W-1:0] MIN_STACKS = 9'd1;

  // request kinds
  localparam logic ACT_VERTEX = 1'b0;
  localparam logic ACT_FACE   = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLICES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STACKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  // cordic, Q2.30 results, 2^32 angle units per turn
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int CORDIC_W     = 34;
  localparam int TRIG_W       = 32;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] ANGLE_QUARTER = 32'sd1073741824;
  localparam logic signed [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
  };

  localparam logic [PHASE_W-1:0] PHASE_QUARTER = 16'd16384;
  localparam logic signed [POS_W-1:0] COORD_LIMIT = 17'sd65535;

  // flags and payload carried beside the first divider
  typedef struct packed {
    logic             res_ok;
    logic             is_face;
    logic             pole_top;
    logic             pole_bot;
    logic             top_fan;
    logic [IDX_W-1:0] idx;
  } side1_t;

  // flags and face corners carried beside the trig pipeline
  typedef struct packed {
    logic             res_ok;
    logic             is_face;
    logic             pole_top;
    logic             pole_bot;
    logic [IDX_W-1:0] ca;
    logic [IDX_W-1:0] cb;
    logic [IDX_W-1:0] cc;
  } side2_t;

endpackage

`default_nettype wire

### rtl/uvs_div.sv
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_div #(
  parameter int NW = 17,
  parameter int DW = 10,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem
);

  logic [DW-1:0] rem0;
  logic [DW-1:0] rs [QW];
  logic [DW-1:0] ds [QW];
  logic [QW-1:0] ns [QW];
  logic [QW-1:0] qs [QW];

  // upper numerator bits form the starting partial remainder
  generate
    if (NW > QW) begin : g_top
      assign rem0 = DW'(num[NW-1:QW]);
    end else begin : g_zero
      assign rem0 = '0;
    end
  endgenerate

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] n_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign r_in = rem0;
      assign d_in = den;
      assign n_in = num[QW-1:0];
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rs[k-1];
      assign d_in = ds[k-1];
      assign n_in = ns[k-1];
      assign q_in = qs[k-1];
    end

    // shift in one numerator bit, subtract when it fits
    assign trial = {r_in, n_in[QW-1-k]};
    assign take  = (trial >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rs[k] <= take ? DW'(trial - {1'b0, d_in}) : DW'(trial);
        qs[k] <= {q_in[QW-2:0], take};
        ns[k] <= n_in;
        ds[k] <= d_in;
      end
    end
  end

  assign quo = qs[QW-1];
  assign rem = rs[QW-1];

endmodule

`default_nettype wire

### rtl/uvs_cordic.sv
// ----------------------------------------------------------------------------
// uvs_cordic
// Pipelined rotation cordic giving cosine and sine of a 16-bit phase.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_cordic (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [uvs_pkg::PHASE_W-1:0]            phase,
  output logic signed [uvs_pkg::TRIG_W-1:0]      cos_val,
  output logic signed [uvs_pkg::TRIG_W-1:0]      sin_val
);

  localparam int N = uvs_pkg::CORDIC_STEPS;
  localparam int W = uvs_pkg::CORDIC_W;

  logic signed [W-1:0] xs  [N+1];
  logic signed [W-1:0] ys  [N+1];
  logic signed [31:0]  ang [N+1];
  logic [N:0]          neg;

  logic signed [31:0] a_raw;
  logic signed [31:0] a_fold;
  logic               fold_neg;

  // fold the angle into the right half plane, half a turn flips the msb
  always_comb begin
    a_raw    = $signed({phase, 16'b0});
    a_fold   = a_raw;
    fold_neg = 1'b0;
    if (a_raw > uvs_pkg::ANGLE_QUARTER || a_raw < -uvs_pkg::ANGLE_QUARTER) begin
      a_fold   = $signed({~a_raw[31], a_raw[30:0]});
      fold_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]  <= uvs_pkg::CORDIC_GAIN;
      ys[0]  <= '0;
      ang[0] <= a_fold;
      neg[0] <= fold_neg;
    end
  end

  // one micro-rotation per stage
  for (genvar k = 0; k < N; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ang[k][31]) begin
          xs[k+1]  <= xs[k] - (ys[k] >>> k);
          ys[k+1]  <= ys[k] + (xs[k] >>> k);
          ang[k+1] <= ang[k] - uvs_pkg::ATAN_TURNS[k];
        end else begin
          xs[k+1]  <= xs[k] + (ys[k] >>> k);
          ys[k+1]  <= ys[k] - (xs[k] >>> k);
          ang[k+1] <= ang[k] + uvs_pkg::ATAN_TURNS[k];
        end
        neg[k+1] <= neg[k];
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= neg[N] ? uvs_pkg::TRIG_W'(-xs[N]) : uvs_pkg::TRIG_W'(xs[N]);
      sin_val <= neg[N] ? uvs_pkg::TRIG_W'(-ys[N]) : uvs_pkg::TRIG_W'(ys[N]);
    end
  end

endmodule

`default_nettype wire

### rtl/uv_sphere_mesh_element_generator_top.sv
// ----------------------------------------------------------------------------
// uv_sphere_mesh_element_generator_top
// Returns one vertex or triangle of a latitude/longitude sphere per request.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets slices,
//   stacks and radius; cfg_ready is always high, write only while idle.
//   in channel (in_valid/in_ready) takes action and element_index; action 0
//   asks for a vertex position, 1 for the three corner indices of a face.
//   out channel (out_valid/out_ready) returns one result per request, in
//   request order, with valid_res low and all fields zero when out of range.
// Pipeline: request register, 17-stage index divider, stage b register,
//   16-stage phase dividers, 18-stage cordic and three multiply/round
//   stages (m1, m2 and the output register).
// Throughput: one request per cycle while out_ready stays high.
// Stall: when a result waits with out_ready low, the whole pipeline holds and
//   in_ready drops; nothing is dropped or repeated.
// Reset: clears all pipeline valid bits and restores slices 8, stacks 4,
//   radius 256.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uv_sphere_mesh_element_generator_top_assert.svh"

module uv_sphere_mesh_element_generator_top #(
  parameter int MAX_SLICES = uvs_pkg::DEF_MAX_SLICES,
  parameter int MAX_STACKS = uvs_pkg::DEF_MAX_STACKS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [uvs_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   action,
  input  logic [uvs_pkg::IDX_W-1:0]              element_index,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   valid_res,
  output logic signed [uvs_pkg::POS_W-1:0]       pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]       pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]       pos_z,
  output logic [uvs_pkg::IDX_W-1:0]              corner_a,
  output logic [uvs_pkg::IDX_W-1:0]              corner_b,
  output logic [uvs_pkg::IDX_W-1:0]              corner_c
);

  localparam int CW     = uvs_pkg::CNT_W;
  localparam int IW     = uvs_pkg::IDX_W;
  localparam int CNT_MX = (1 << CW) - 1;
  localparam int S_CAP  = (MAX_SLICES > CNT_MX) ? CNT_MX : MAX_SLICES;
  localparam int T_CAP  = (MAX_STACKS > CNT_MX) ? CNT_MX : MAX_STACKS;
  localparam int LAT1   = IW;
  localparam int LAT2   = uvs_pkg::PHASE_W + uvs_pkg::CORDIC_LAT;
  localparam int PW     = uvs_pkg::RAD_W + 1 + uvs_pkg::TRIG_W;

  // configuration registers
  logic [CW-1:0]               slices;
  logic [CW-1:0]               stacks;
  logic [uvs_pkg::RAD_W-1:0]   radius;
  logic [CW-1:0]               s_eff;
  logic [CW-1:0]               t_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slices <= uvs_pkg::RST_SLICES;
      stacks <= uvs_pkg::RST_STACKS;
      radius <= uvs_pkg::RST_RADIUS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        uvs_pkg::REG_SLICES: slices <= cfg_data[CW-1:0];
        uvs_pkg::REG_STACKS: stacks <= cfg_data[CW-1:0];
        uvs_pkg::REG_RADIUS: radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped mesh size
  always_ff @(posedge clk) begin
    if (rst) begin
      s_eff <= uvs_pkg::RST_SLICES;
      t_eff <= uvs_pkg::RST_STACKS;
    end else begin
      s_eff <= (slices < uvs_pkg::MIN_SLICES) ? uvs_pkg::MIN_SLICES :
               (slices > CW'(S_CAP)) ? CW'(S_CAP) : slices;
      t_eff <= (stacks < uvs_pkg::MIN_STACKS) ? uvs_pkg::MIN_STACKS :
               (stacks > CW'(T_CAP)) ? CW'(T_CAP) : stacks;
    end
  end

  // global advance: the pipeline moves when the output slot is empty or being read
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage a: request register
  logic          a_valid;
  logic          a_action;
  logic [IW-1:0] a_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_action <= action;
      a_idx    <= element_index;
    end
  end

  // range checks and split into ring/column
  logic [2*CW-1:0]       st;
  logic [2*CW:0]         nv_last;
  logic                  is_face;
  uvs_pkg::side1_t       a_side;
  logic [IW-1:0]         d1_num;
  logic [CW:0]           d1_den;

  assign st      = (2*CW)'(s_eff) * (2*CW)'(t_eff);
  assign nv_last = (2*CW+1)'(st) + 1'b1;
  assign is_face = (a_action == uvs_pkg::ACT_FACE);

  always_comb begin
    a_side.is_face  = is_face;
    a_side.idx      = a_idx;
    a_side.top_fan  = (a_idx < IW'(s_eff));
    a_side.pole_top = !is_face && (a_idx == '0);
    a_side.pole_bot = !is_face && ((2*CW+1)'(a_idx) == nv_last);
    if (is_face) begin
      a_side.res_ok = ((2*CW+1)'(a_idx) < {st, 1'b0});
      d1_num        = a_idx - IW'(s_eff);
      d1_den        = {s_eff, 1'b0};
    end else begin
      a_side.res_ok = ((2*CW+1)'(a_idx) <= nv_last);
      d1_num        = a_idx - IW'(1);
      d1_den        = {1'b0, s_eff};
    end
  end

  // index divider: ring and column for vertices, band and slot for faces
  logic [IW-1:0] q1;
  logic [CW:0]   r1;

  uvs_div #(
    .NW(IW),
    .DW(CW + 1),
    .QW(IW)
  ) u_div_idx (
    .clk(clk),
    .en (adv),
    .num(d1_num),
    .den(d1_den),
    .quo(q1),
    .rem(r1)
  );

  uvs_pkg::side1_t sd1 [LAT1];
  logic [LAT1-1:0] v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= '0;
    end else if (adv) begin
      v1 <= {v1[LAT1-2:0], a_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd1[0] <= a_side;
      for (int k = 1; k < LAT1; k++) begin
        sd1[k] <= sd1[k-1];
      end
    end
  end

  // stage b: face corners and phase dividends
  uvs_pkg::side1_t sd1_o;
  logic [2*CW:0]   i_s;
  logic [2*CW:0]   s_w;
  logic [CW:0]     jm;
  logic [CW:0]     njm;
  logic [CW:0]     ib;
  logic [CW:0]     nib;
  logic [CW:0]     tb;
  logic [CW:0]     tc;
  logic [2*CW:0]   fa;
  logic [2*CW:0]   fb;
  logic [2*CW:0]   fc;
  uvs_pkg::side2_t b_side_next;
  logic [24:0]     th_num_next;
  logic [24:0]     ph_num_next;

  assign sd1_o = sd1[LAT1-1];
  assign i_s   = (2*CW+1)'(q1[CW-1:0]) * (2*CW+1)'(s_eff);
  assign s_w   = (2*CW+1)'(s_eff);
  assign jm    = (CW+1)'(r1[CW:1]) + 1'b1;
  assign njm   = (jm < {1'b0, s_eff}) ? jm + 1'b1 : (CW+1)'(1);
  assign ib    = (CW+1)'(r1[CW-1:0]) + 1'b1;
  assign nib   = (ib < {1'b0, s_eff}) ? ib + 1'b1 : (CW+1)'(1);
  assign tb    = (CW+1)'(sd1_o.idx[CW-1:0]) + 1'b1;
  assign tc    = (tb < {1'b0, s_eff}) ? tb + 1'b1 : (CW+1)'(1);

  always_comb begin
    fa = '0;
    fb = '0;
    fc = '0;
    if (sd1_o.res_ok && sd1_o.is_face) begin
      priority if (sd1_o.top_fan) begin
        fb = (2*CW+1)'(tb);
        fc = (2*CW+1)'(tc);
      end else if (q1 < IW'(t_eff) - IW'(1)) begin
        // middle band, even slot is the upper-left triangle of the quad
        fb = i_s + s_w + (2*CW+1)'(jm);
        if (!r1[0]) begin
          fa = i_s + (2*CW+1)'(jm);
          fc = i_s + (2*CW+1)'(njm);
        end else begin
          fa = i_s + (2*CW+1)'(njm);
          fc = i_s + s_w + (2*CW+1)'(njm);
        end
      end else begin
        // bottom fan around the last vertex
        fa = nv_last;
        fb = i_s + (2*CW+1)'(ib);
        fc = i_s + (2*CW+1)'(nib);
      end
    end
    b_side_next.res_ok   = sd1_o.res_ok;
    b_side_next.is_face  = sd1_o.is_face;
    b_side_next.pole_top = sd1_o.pole_top;
    b_side_next.pole_bot = sd1_o.pole_bot;
    b_side_next.ca       = fa[IW-1:0];
    b_side_next.cb       = fb[IW-1:0];
    b_side_next.cc       = fc[IW-1:0];
    th_num_next = {r1[CW-1:0], 16'b0} + 25'(s_eff[CW-1:1]);
    ph_num_next = {q1[CW-1:0] + CW'(1), 16'b0} + 25'(t_eff) + 25'd1;
  end

  logic            b_valid;
  uvs_pkg::side2_t b_side;
  logic [24:0]     b_th_num;
  logic [24:0]     b_ph_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= v1[LAT1-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_side   <= b_side_next;
      b_th_num <= th_num_next;
      b_ph_num <= ph_num_next;
    end
  end

  // phase dividers
  logic [uvs_pkg::PHASE_W-1:0] q_th;
  logic [uvs_pkg::PHASE_W-1:0] q_ph;
  logic [uvs_pkg::PHASE_W-1:0] ph_phase;
  logic [CW+1:0]               ph_den;

  assign ph_den = {1'b0, t_eff, 1'b0} + (CW+2)'(2);

  uvs_div #(
    .NW(25),
    .DW(CW),
    .QW(uvs_pkg::PHASE_W)
  ) u_div_theta (
    .clk(clk),
    .en (adv),
    .num(b_th_num),
    .den(s_eff),
    .quo(q_th),
    .rem()
  );

  uvs_div #(
    .NW(25),
    .DW(CW + 2),
    .QW(uvs_pkg::PHASE_W)
  ) u_div_phi (
    .clk(clk),
    .en (adv),
    .num(b_ph_num),
    .den(ph_den),
    .quo(q_ph),
    .rem()
  );

  assign ph_phase = q_ph - uvs_pkg::PHASE_QUARTER;

  // trig units
  logic signed [uvs_pkg::TRIG_W-1:0] cp;
  logic signed [uvs_pkg::TRIG_W-1:0] sp;
  logic signed [uvs_pkg::TRIG_W-1:0] ct;
  logic signed [uvs_pkg::TRIG_W-1:0] stv;

  uvs_cordic u_cordic_phi (
    .clk    (clk),
    .en     (adv),
    .phase  (ph_phase),
    .cos_val(cp),
    .sin_val(sp)
  );

  uvs_cordic u_cordic_theta (
    .clk    (clk),
    .en     (adv),
    .phase  (q_th),
    .cos_val(ct),
    .sin_val(stv)
  );

  uvs_pkg::side2_t sd2 [LAT2];
  logic [LAT2-1:0] v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= '0;
    end else if (adv) begin
      v2 <= {v2[LAT2-2:0], b_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd2[0] <= b_side;
      for (int k = 1; k < LAT2; k++) begin
        sd2[k] <= sd2[k-1];
      end
    end
  end

  // stage m1: horizontal terms cos(phi)*cos(theta), cos(phi)*sin(theta)
  logic signed [63:0] prod_x;
  logic signed [63:0] prod_z;
  logic signed [63:0] rnd_x;
  logic signed [63:0] rnd_z;

  assign prod_x = cp * ct;
  assign prod_z = cp * stv;
  assign rnd_x  = prod_x + 64'sd536870912;
  assign rnd_z  = prod_z + 64'sd536870912;

  logic                              m1_valid;
  uvs_pkg::side2_t                   m1_side;
  logic signed [uvs_pkg::TRIG_W-1:0] m1_x;
  logic signed [uvs_pkg::TRIG_W-1:0] m1_y;
  logic signed [uvs_pkg::TRIG_W-1:0] m1_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= v2[LAT2-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_side <= sd2[LAT2-1];
      m1_x    <= rnd_x[61:30];
      m1_y    <= sp;
      m1_z    <= rnd_z[61:30];
    end
  end

  // stage m2: scale by radius
  logic signed [uvs_pkg::RAD_W:0] rad_s;
  logic                           m2_valid;
  uvs_pkg::side2_t                m2_side;
  logic signed [PW-1:0]           m2_px;
  logic signed [PW-1:0]           m2_py;
  logic signed [PW-1:0]           m2_pz;

  assign rad_s = $signed({1'b0, radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (adv) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_side <= m1_side;
      m2_px   <= rad_s * m1_x;
      m2_py   <= rad_s * m1_y;
      m2_pz   <= rad_s * m1_z;
    end
  end

  // round half up by 2^30 and clip to the coordinate range
  function automatic logic signed [uvs_pkg::POS_W-1:0] sat_coord(
    input logic signed [PW-1:0] p
  );
    logic signed [PW-1:0] r;
    logic signed [PW-31:0] v;
    r = p + PW'(64'sd536870912);
    v = r[PW-1:30];
    if (v > (PW-30)'(uvs_pkg::COORD_LIMIT)) begin
      return uvs_pkg::COORD_LIMIT;
    end else if (v < -(PW-30)'(uvs_pkg::COORD_LIMIT)) begin
      return -uvs_pkg::COORD_LIMIT;
    end
    return v[uvs_pkg::POS_W-1:0];
  endfunction

  // result select
  logic [uvs_pkg::POS_W-1:0]         rad17;
  logic                              vr_next;
  logic signed [uvs_pkg::POS_W-1:0]  px_next;
  logic signed [uvs_pkg::POS_W-1:0]  py_next;
  logic signed [uvs_pkg::POS_W-1:0]  pz_next;
  logic [IW-1:0]                     ca_next;
  logic [IW-1:0]                     cb_next;
  logic [IW-1:0]                     cc_next;

  assign rad17 = {1'b0, radius};

  always_comb begin
    vr_next = m2_side.res_ok;
    px_next = '0;
    py_next = '0;
    pz_next = '0;
    ca_next = '0;
    cb_next = '0;
    cc_next = '0;
    if (m2_side.res_ok) begin
      priority if (m2_side.is_face) begin
        ca_next = m2_side.ca;
        cb_next = m2_side.cb;
        cc_next = m2_side.cc;
      end else if (m2_side.pole_top) begin
        py_next = $signed(-rad17);
      end else if (m2_side.pole_bot) begin
        py_next = $signed(rad17);
      end else begin
        px_next = sat_coord(m2_px);
        py_next = sat_coord(m2_py);
        pz_next = sat_coord(m2_pz);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      valid_res <= vr_next;
      pos_x     <= px_next;
      pos_y     <= py_next;
      pos_z     <= pz_next;
      corner_a  <= ca_next;
      corner_b  <= cb_next;
      corner_c  <= cc_next;
    end
  end

  // checks
  `UVS_CHECK(a_invalid_zero, out_valid && !valid_res, pos_x == '0 && pos_y == '0 && pos_z == '0 && corner_a == '0 && corner_b == '0 && corner_c == '0)
  `UVS_CHECK(a_vertex_no_corners, out_valid && valid_res && (pos_x != '0 || pos_y != '0 || pos_z != '0), corner_a == '0 && corner_b == '0 && corner_c == '0)
  `UVS_CHECK(a_face_distinct, out_valid && valid_res && corner_b != '0, corner_b != corner_c && corner_a != corner_b)
  `UVS_CHECK_NEXT(a_request_enters, in_valid && in_ready, a_valid)

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uv sphere element generator testbench
// Sends vertex and face requests under a series of mesh sizes and radii,
// predicts the untyped answers with a behavioral cordic model, and checks the
// results in order. Both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IW = uvs_pkg::IDX_W;
  localparam int PW = uvs_pkg::POS_W;

  // register index that names no register
  localparam logic [uvs_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct {
    logic                 ok;
    logic signed [PW-1:0] x, y, z;
    logic [IW-1:0]        a, b, c;
  } elem_t;

  typedef struct {
    logic          act;
    logic [IW-1:0] idx;
    bit            typed;
    elem_t         want;
  } row_t;

  typedef struct {
    logic [8:0]  s, t;
    logic [15:0] r;
  } mesh_cfg_t;

  localparam longint TURN = 64'sd4294967296;
  localparam longint HALF = 64'sd2147483648;
  localparam longint QUART = 64'sd1073741824;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [uvs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [uvs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = uvs_pkg::ACT_VERTEX;
  logic [IW-1:0] element_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic valid_res;
  logic signed [PW-1:0] pos_x, pos_y, pos_z;
  logic [IW-1:0] corner_a, corner_b, corner_c;

  // mirrored register state
  logic [8:0] mesh_slices = uvs_pkg::RST_SLICES;
  logic [8:0] mesh_stacks = uvs_pkg::RST_STACKS;
  logic [15:0] mesh_radius = uvs_pkg::RST_RADIUS;

  elem_t pending_elems[$];
  int errors = 0;
  int n_vertex = 0, n_face = 0, n_miss = 0, n_checked = 0;

  uv_sphere_mesh_element_generator_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .element_index(element_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .valid_res(valid_res), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c)
  );

  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic longint rnd_shift(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  // sine and cosine of a 16-bit phase, Q2.30
  task automatic sin_cos(input logic [15:0] ph, output longint co, output longint si);
    longint ang, x, y, nx;
    bit flip;
    ang = longint'(ph) * 65536;
    x = uvs_pkg::CORDIC_GAIN;
    y = 0;
    flip = 0;
    if (ang >= HALF) ang -= TURN;
    if (ang > QUART) begin
      ang -= HALF;
      flip = 1;
    end else if (ang < -QUART) begin
      ang += HALF;
      flip = 1;
    end
    for (int k = 0; k < uvs_pkg::CORDIC_STEPS; k++) begin
      if (ang >= 0) begin
        nx = x - (y >>> k);
        y = y + (x >>> k);
        ang -= uvs_pkg::ATAN_TURNS[k];
      end else begin
        nx = x + (y >>> k);
        y = y - (x >>> k);
        ang += uvs_pkg::ATAN_TURNS[k];
      end
      x = nx;
    end
    co = flip ? -x : x;
    si = flip ? -y : y;
  endtask

  function automatic logic signed [PW-1:0] scale_coord(longint trig);
    longint v;
    v = rnd_shift(longint'(mesh_radius) * trig, 30);
    if (v > 65535) v = 65535;
    if (v < -65535) v = -65535;
    return v[PW-1:0];
  endfunction

  function automatic longint eff_slices();
    return mesh_slices < 3 ? 3 : (mesh_slices > 256 ? 256 : mesh_slices);
  endfunction

  function automatic longint eff_stacks();
    return mesh_stacks < 1 ? 1 : (mesh_stacks > 256 ? 256 : mesh_stacks);
  endfunction

  // expected element for one request
  task automatic predict_elem(input logic act, input logic [IW-1:0] idx,
                              output elem_t e);
    longint s, t, nv, nf, mid, g, i, j, r, nj, ni, tph, pph;
    longint cp, sp, ct, st, ca, cb, cc;
    s = eff_slices();
    t = eff_stacks();
    e = '{default: '0};
    if (act == uvs_pkg::ACT_VERTEX) begin
      nv = s * t + 2;
      if (idx >= nv) return;
      e.ok = 1;
      if (idx == 0) begin
        e.y = -$signed({1'b0, mesh_radius});
      end else if (idx == nv - 1) begin
        e.y = $signed({1'b0, mesh_radius});
      end else begin
        r = idx - 1;
        i = r / s;
        j = r % s;
        tph = (65536 * j + s / 2) / s;
        pph = ((65536 * (i + 1) + (t + 1)) / (2 * (t + 1)) - 16384) & 16'hFFFF;
        sin_cos(pph[15:0], cp, sp);
        sin_cos(tph[15:0], ct, st);
        e.x = scale_coord(rnd_shift(cp * ct, 30));
        e.y = scale_coord(sp);
        e.z = scale_coord(rnd_shift(cp * st, 30));
      end
    end else begin
      nf = 2 * s * t;
      mid = (t - 1) * 2 * s;
      if (idx >= nf) return;
      if (idx < s) begin
        ca = 0;
        cb = idx + 1;
        cc = (idx + 1 < s) ? idx + 2 : 1;
      end else if (idx - s < mid) begin
        g = idx - s;
        i = g / (2 * s);
        r = g % (2 * s);
        j = r / 2 + 1;
        nj = (j < s) ? j + 1 : 1;
        if (r % 2 == 0) begin
          ca = i * s + j;
          cb = (i + 1) * s + j;
          cc = i * s + nj;
        end else begin
          ca = i * s + nj;
          cb = (i + 1) * s + j;
          cc = (i + 1) * s + nj;
        end
      end else begin
        i = idx - s - mid + 1;
        ni = (i < s) ? i + 1 : 1;
        ca = s * t + 1;
        cb = (t - 1) * s + i;
        cc = (t - 1) * s + ni;
      end
      e.ok = 1;
      e.a = ca[IW-1:0];
      e.b = cb[IW-1:0];
      e.c = cc[IW-1:0];
    end
  endtask

  // one request; entered and left at a falling edge
  task automatic send_request(logic act, logic [IW-1:0] idx, bit typed, elem_t want);
    elem_t e;
    in_valid = 1'b1;
    action = act;
    element_index = idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) e = want;
    else predict_elem(act, idx, e);
    pending_elems.push_back(e);
    if (act == uvs_pkg::ACT_FACE) n_face++;
    else n_vertex++;
    if (!e.ok) n_miss++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [uvs_pkg::CFG_IDX_W-1:0] ri, logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = ri;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (ri)
      uvs_pkg::REG_SLICES: mesh_slices = val[8:0];
      uvs_pkg::REG_STACKS: mesh_stacks = val[8:0];
      uvs_pkg::REG_RADIUS: mesh_radius = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // let the pipeline empty out before touching registers
  task automatic drain();
    in_valid = 1'b0;
    while (pending_elems.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    elem_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_elems.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending_elems.pop_front();
        n_checked++;
        check_field("valid_res", e.ok, valid_res);
        check_field("pos_x", e.x, pos_x);
        check_field("pos_y", e.y, pos_y);
        check_field("pos_z", e.z, pos_z);
        check_field("corner_a", e.a, corner_a);
        check_field("corner_b", e.b, corner_b);
        check_field("corner_c", e.c, corner_c);
      end
    end
  end

  // receiver stall pattern, mode redrawn each time stall_cnt wraps to zero
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(negedge clk) begin
    if (stall_cnt == 0) stall_mode <= $urandom_range(0, 3);
    stall_cnt <= (stall_cnt + 1) % 64;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= stall_cnt[3];
    endcase
  end

  row_t dir_rows[$];
  mesh_cfg_t mesh_cfgs[7];

  function automatic row_t mk_row(logic act, logic [IW-1:0] idx, bit typed,
                                  logic ok, longint y, longint a, longint b, longint c);
    row_t rw;
    rw.act = act;
    rw.idx = idx;
    rw.typed = typed;
    rw.want = '{ok: ok, x: '0, y: y[PW-1:0], z: '0,
                a: a[IW-1:0], b: b[IW-1:0], c: c[IW-1:0]};
    return rw;
  endfunction

  initial begin
    longint n;
    logic act;
    logic [IW-1:0] idx;
    int burst, sel;
    elem_t none;

    none = '{default: '0};
    // reset mesh: 8 slices, 4 stacks, radius 256
    dir_rows.push_back(mk_row(uvs_pkg::ACT_VERTEX, 0, 1, 1, -256, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_VERTEX, 33, 1, 1, 256, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_VERTEX, 34, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_VERTEX, 17'h1FFFF, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_FACE, 0, 1, 1, 0, 0, 1, 2));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_FACE, 7, 1, 1, 0, 0, 8, 1));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_FACE, 8, 1, 1, 0, 1, 9, 2));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_FACE, 63, 1, 1, 0, 33, 32, 25));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_FACE, 64, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_FACE, 17'h1FFFF, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_VERTEX, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_VERTEX, 3, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_VERTEX, 8, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_VERTEX, 16, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_VERTEX, 25, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_VERTEX, 32, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_FACE, 9, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_FACE, 23, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_FACE, 40, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(uvs_pkg::ACT_FACE, 56, 0, 0, 0, 0, 0, 0));

    // mesh sizes per phase, extremes and clamped values included
    mesh_cfgs[0] = '{s: 9'd8,   t: 9'd4,   r: 16'd256};
    mesh_cfgs[1] = '{s: 9'd3,   t: 9'd1,   r: 16'd65535};
    mesh_cfgs[2] = '{s: 9'd256, t: 9'd256, r: 16'd1};
    mesh_cfgs[3] = '{s: 9'd0,   t: 9'd0,   r: 16'd0};
    mesh_cfgs[4] = '{s: 9'd511, t: 9'd511, r: 16'd300};
    mesh_cfgs[5] = '{s: 9'd5,   t: 9'd7,   r: 16'd40000};
    mesh_cfgs[6] = '{s: 9'd13,  t: 9'd2,   r: 16'd777};

    repeat (4) @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[k]) send_request(dir_rows[k].act, dir_rows[k].idx,
                                       dir_rows[k].typed, dir_rows[k].want);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(uvs_pkg::REG_SLICES, 16'(mesh_cfgs[ph].s));
        write_reg(uvs_pkg::REG_STACKS, 16'(mesh_cfgs[ph].t));
        write_reg(uvs_pkg::REG_RADIUS, mesh_cfgs[ph].r);
        // this index names no register; the write must change nothing
        write_reg(REG_NONE, 16'($urandom));
      end
      burst = 0;
      for (int it = 0; it < 255; it++) begin
        act = $urandom_range(0, 1);
        n = (act == uvs_pkg::ACT_FACE) ? 2 * eff_slices() * eff_stacks()
                                       : eff_slices() * eff_stacks() + 2;
        sel = $urandom_range(0, 9);
        if (sel < 7) idx = IW'($urandom_range(0, int'(n - 1)));
        else if (sel == 7) idx = IW'(n - 2 + $urandom_range(0, 3));
        else idx = IW'($urandom);
        send_request(act, idx, 0, none);
        // bursts with random gaps between them
        if (burst == 0) begin
          burst = $urandom_range(1, 24);
          if ($urandom_range(0, 2) != 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
          end
        end else begin
          burst--;
        end
      end
    end

    in_valid = 1'b0;
    while (pending_elems.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (pending_elems.size() != 0) errors++;

    $display("covered %0d vertex and %0d face requests over 7 mesh settings,",
             n_vertex, n_face);
    $display("%0d of them out of range, %0d results checked", n_miss, n_checked);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
